### sv/csr_bool_matrix_store_unit_macros.svh
// Assertion macros used by the store unit RTL.
`ifndef CSR_BOOL_MATRIX_STORE_UNIT_MACROS_SVH
`define CSR_BOOL_MATRIX_STORE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSRBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSRBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/csrbm_pkg.sv
package csrbm_pkg;

    // Matrix bounds.
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    // Derived widths.
    localparam int SIZE_W  = 7;                          // size register width
    localparam int QROW_W  = 6;                          // query row field
    localparam int QCOL_W  = 6;                          // query column field
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);       // load row, row pointer index
    localparam int COL_W   = $clog2(MAX_COLS);           // stored column index
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);    // element count
    localparam int ADDR_W  = $clog2(STORE_DEPTH);        // column store address
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

    // Input mode codes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [SIZE_W-1:0] MAX_ROWS_V = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] MAX_COLS_V = SIZE_W'(MAX_COLS);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_END,
        ST_SCAN
    } state_t;

    // Zero reads as one, anything above the limit reads as the limit.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

### sv/csr_bool_matrix_store_unit.sv
// Compressed-sparse-row store for a boolean matrix with membership queries.
// Command channel: a word is taken on a rising edge with start high and busy low.
// mode = 0 loads the next dense bit (row-major); mode = 1 asks whether element
// (query_row, query_col) is set. Each word gives exactly one result, shown for
// one cycle with done high; the receiver cannot stall and must take it then.
// A load word, an out-of-range query and a query of a row not yet loaded give
// their result on the cycle after acceptance, and busy stays low.
// Any other query reads the row's two pointers from the row-pointer memory,
// then scans the row's column indices one per cycle through the column memory
// read port, stopping early on a hit; busy is high until the result is shown.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// rows_in_use, index 1 cols_in_use. Either write restarts the load. cfg_ready
// is high only while no query is running and no start is offered.
// Reset clears the count and load position and sets the sizes to 64 x 64; the
// stores need no clearing pass, so the block is ready on the first cycle after reset.
`include "csr_bool_matrix_store_unit_macros.svh"

module csr_bool_matrix_store_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Command channel
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic                               bit_value,
    input  logic [csrbm_pkg::QROW_W-1:0]       query_row,
    input  logic [csrbm_pkg::QCOL_W-1:0]       query_col,
    // Result channel
    output logic                               done,
    output logic                               hit,
    output logic                               bad_address,
    output logic [csrbm_pkg::CNT_W-1:0]        stored_count,
    output logic                               load_complete,
    // Configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csrbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csrbm_pkg::SIZE_W-1:0]       cfg_data
);

    localparam int ROW_W  = csrbm_pkg::ROW_W;
    localparam int COL_W  = csrbm_pkg::COL_W;
    localparam int CNT_W  = csrbm_pkg::CNT_W;
    localparam int ADDR_W = csrbm_pkg::ADDR_W;
    localparam int SIZE_W = csrbm_pkg::SIZE_W;

    // Control and load state.
    csrbm_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               loaded_reg, loaded_next;
    logic [SIZE_W-1:0]  rows_reg, rows_next;
    logic [SIZE_W-1:0]  cols_reg, cols_next;
    logic               done_reg, done_next;
    logic               pend_reg, pend_next;

    // Query payload.
    logic [csrbm_pkg::QROW_W-1:0] qrow_reg, qrow_next;
    logic [csrbm_pkg::QCOL_W-1:0] qcol_reg, qcol_next;
    logic               use_count_reg, use_count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic               hit_reg, hit_next;
    logic               bad_reg, bad_next;

    // Memory ports.
    logic               col_we;
    logic [ADDR_W-1:0]  col_waddr;
    logic [COL_W-1:0]   col_wdata;
    logic [COL_W-1:0]   col_rdata;
    logic               rs_we;
    logic [ROW_W-1:0]   rs_waddr;
    logic [CNT_W-1:0]   rs_wdata;
    logic [ROW_W-1:0]   rs_raddr;
    logic [CNT_W-1:0]   rs_rdata;

    // Load datapath.
    logic               accept;
    logic               query_bad;
    logic [CNT_W-1:0]   base_count;
    logic [ROW_W-1:0]   base_row;
    logic [COL_W-1:0]   base_col;
    logic               store_bit;
    logic [CNT_W-1:0]   load_count;
    logic [SIZE_W-1:0]  col_inc;
    logic               row_end;
    logic [ROW_W-1:0]   load_row;
    logic               scan_match;

    // Column indices, one entry per stored element.
    csrbm_ram #(
        .WIDTH (COL_W),
        .DEPTH (csrbm_pkg::STORE_DEPTH)
    ) u_col_store (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (ptr_reg[ADDR_W-1:0]),
        .rdata (col_rdata)
    );

    // Row pointers; entry zero is never written, the start of row zero is taken as zero.
    csrbm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (csrbm_pkg::MAX_ROWS + 1)
    ) u_row_start (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (rs_wdata),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    assign busy      = (state_reg != csrbm_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = (state_reg == csrbm_pkg::ST_IDLE) && !start;

    // A load after a complete matrix starts over from the origin.
    assign base_count = loaded_reg ? '0 : count_reg;
    assign base_row   = loaded_reg ? '0 : row_reg;
    assign base_col   = loaded_reg ? '0 : col_reg;
    assign store_bit  = bit_value && (base_count < CNT_W'(csrbm_pkg::STORE_DEPTH));
    assign load_count = base_count + CNT_W'(store_bit);
    assign col_inc    = SIZE_W'(base_col) + SIZE_W'(1);
    assign row_end    = (col_inc >= cols_reg);
    assign load_row   = base_row + ROW_W'(row_end);

    assign col_waddr = base_count[ADDR_W-1:0];
    assign col_wdata = base_col;
    assign rs_waddr  = load_row;
    assign rs_wdata  = load_count;

    assign query_bad = (SIZE_W'(query_row) >= rows_reg) || (SIZE_W'(query_col) >= cols_reg);

    // The row start is read as the query is taken, the row end in the cycle after.
    assign rs_raddr = (state_reg == csrbm_pkg::ST_IDLE) ? ROW_W'(query_row)
                                                        : ROW_W'(qrow_reg) + ROW_W'(1);

    assign scan_match = pend_reg && (col_rdata == qcol_reg);

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= csrbm_pkg::ST_IDLE;
            count_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            loaded_reg <= 1'b0;
            rows_reg   <= csrbm_pkg::MAX_ROWS_V;
            cols_reg   <= csrbm_pkg::MAX_COLS_V;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            loaded_reg <= loaded_next;
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qrow_reg      <= qrow_next;
        qcol_reg      <= qcol_next;
        use_count_reg <= use_count_next;
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        hit_reg       <= hit_next;
        bad_reg       <= bad_next;
    end

    // Sequencer: loads, size writes and short answers at acceptance, otherwise a row scan.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        loaded_next    = loaded_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        done_next      = 1'b0;
        pend_next      = pend_reg;
        qrow_next      = qrow_reg;
        qcol_next      = qcol_reg;
        use_count_next = use_count_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        hit_next       = hit_reg;
        bad_next       = bad_reg;
        col_we         = 1'b0;
        rs_we          = 1'b0;

        unique case (state_reg)
            csrbm_pkg::ST_IDLE:
            begin
                priority if (accept && (mode == csrbm_pkg::MODE_LOAD))
                begin
                    col_we      = store_bit;
                    rs_we       = row_end;
                    count_next  = load_count;
                    row_next    = load_row;
                    col_next    = row_end ? '0 : col_inc[COL_W-1:0];
                    loaded_next = row_end && (SIZE_W'(load_row) >= rows_reg);
                    hit_next    = 1'b0;
                    bad_next    = 1'b0;
                    done_next   = 1'b1;
                end
                else if (accept)
                begin
                    qrow_next      = query_row;
                    qcol_next      = query_col;
                    use_count_next = !loaded_reg && (ROW_W'(query_row) == row_reg);
                    hit_next       = 1'b0;
                    bad_next       = query_bad;
                    if (query_bad || (!loaded_reg && (ROW_W'(query_row) > row_reg)))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = csrbm_pkg::ST_START;
                    end
                end
                else if (cfg_valid && cfg_ready && ((cfg_index == csrbm_pkg::CFG_ROWS_IN_USE)
                         || (cfg_index == csrbm_pkg::CFG_COLS_IN_USE)))
                begin
                    if (cfg_index == csrbm_pkg::CFG_ROWS_IN_USE)
                    begin
                        rows_next = csrbm_pkg::clamp_size(cfg_data, csrbm_pkg::MAX_ROWS_V);
                    end
                    else
                    begin
                        cols_next = csrbm_pkg::clamp_size(cfg_data, csrbm_pkg::MAX_COLS_V);
                    end
                    count_next  = '0;
                    row_next    = '0;
                    col_next    = '0;
                    loaded_next = 1'b0;
                end
                else
                begin
                    state_next = csrbm_pkg::ST_IDLE;
                end
            end

            // Row start arrives; row end pointer is being read.
            csrbm_pkg::ST_START:
            begin
                ptr_next   = (qrow_reg == '0) ? '0 : rs_rdata;
                state_next = csrbm_pkg::ST_END;
            end

            // Row end arrives; the row under load ends at the count instead.
            csrbm_pkg::ST_END:
            begin
                end_next   = use_count_reg ? count_reg : rs_rdata;
                pend_next  = 1'b0;
                state_next = csrbm_pkg::ST_SCAN;
            end

            // One column index read and one compare per cycle.
            csrbm_pkg::ST_SCAN:
            begin
                if (scan_match || ((ptr_reg >= end_reg) && !pend_reg))
                begin
                    hit_next   = scan_match;
                    done_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = csrbm_pkg::ST_IDLE;
                end
                else
                begin
                    pend_next = (ptr_reg < end_reg);
                    ptr_next  = ptr_reg + CNT_W'(ptr_reg < end_reg);
                end
            end

            default:
            begin
                state_next = csrbm_pkg::ST_IDLE;
            end
        endcase
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign bad_address   = bad_reg;
    assign stored_count  = count_reg;
    assign load_complete = loaded_reg;

    `CSRBM_ASSERT_NOW(a_done_idle, done, !busy, "Result shown while a query still runs.")
    `CSRBM_ASSERT_NOW(a_bad_miss, done && bad_address, !hit, "Out-of-range query reported a hit.")
    `CSRBM_ASSERT_NOW(a_count_max, 1'b1, count_reg <= CNT_W'(csrbm_pkg::STORE_DEPTH),
        "Element count beyond the column store depth.")
    `CSRBM_ASSERT_NEXT(a_bad_fast, accept && (mode == csrbm_pkg::MODE_QUERY) && query_bad,
        done && bad_address, "Out-of-range query not answered on the next cycle.")
    `CSRBM_ASSERT_NEXT(a_load_fast, accept && (mode == csrbm_pkg::MODE_LOAD),
        done && !hit && !bad_address, "Load word not answered on the next cycle.")

endmodule

### sv/csrbm_ram.sv
module csrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sim/csr_bool_matrix_store_unit_test.sv
module csr_bool_matrix_store_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS    = csrbm_pkg::MAX_ROWS;
    localparam int MAX_COLS    = csrbm_pkg::MAX_COLS;
    localparam int STORE_DEPTH = csrbm_pkg::STORE_DEPTH;
    localparam int SIZE_W      = csrbm_pkg::SIZE_W;
    localparam int QROW_W      = csrbm_pkg::QROW_W;
    localparam int QCOL_W      = csrbm_pkg::QCOL_W;
    localparam int ROW_W       = csrbm_pkg::ROW_W;
    localparam int COL_W       = csrbm_pkg::COL_W;
    localparam int CNT_W       = csrbm_pkg::CNT_W;
    localparam int CFG_IDX_W   = csrbm_pkg::CFG_IDX_W;

    // Index that selects no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = MAX_COLS + 16;
    localparam int RANDOM_WORDS  = 1700;

    typedef struct packed {
        logic              mode;
        logic              bit_value;
        logic [QROW_W-1:0] query_row;
        logic [QCOL_W-1:0] query_col;
    } csr_word_t;

    typedef struct packed {
        logic             hit;
        logic             bad_address;
        logic [CNT_W-1:0] stored_count;
        logic             load_complete;
    } csr_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              mode = csrbm_pkg::MODE_LOAD;
    logic              bit_value = 1'b0;
    logic [QROW_W-1:0] query_row = '0;
    logic [QCOL_W-1:0] query_col = '0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic              busy;
    logic              done;
    logic              hit;
    logic              bad_address;
    logic [CNT_W-1:0]  stored_count;
    logic              load_complete;
    logic              cfg_ready;

    csr_bool_matrix_store_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .bit_value     (bit_value),
        .query_row     (query_row),
        .query_col     (query_col),
        .done          (done),
        .hit           (hit),
        .bad_address   (bad_address),
        .stored_count  (stored_count),
        .load_complete (load_complete),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Words waiting to be sent, and answers predicted for words already taken.
    csr_word_t   words_to_send[$];
    csr_answer_t answers_due[$];
    csr_word_t   word_on_bus;
    int          words_in_flight = 0;
    int          words_queued = 0;
    int          gap_left = 0;
    int          gap_odds = 0;
    int          fail_count = 0;
    int          loads_taken = 0;
    int          queries_taken = 0;
    int          flagged_bad = 0;
    int          hits_seen = 0;
    int          matrices_done = 0;
    int          size_writes = 0;

    // Mirror of the block: compressed rows built from the dense bit stream.
    logic [COL_W-1:0]  mir_col_store [STORE_DEPTH];
    logic [CNT_W-1:0]  mir_row_ptr [MAX_ROWS+1];
    logic [CNT_W-1:0]  mir_count;
    logic [ROW_W-1:0]  mir_row;
    logic [COL_W-1:0]  mir_col;
    logic              mir_loaded;
    logic [SIZE_W-1:0] mir_rows;
    logic [SIZE_W-1:0] mir_cols;

    function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] raw, input int lim);
        if (raw == '0)
            return SIZE_W'(1);
        if (int'(raw) > lim)
            return SIZE_W'(lim);
        return raw;
    endfunction

    function automatic void mirror_restart();
        mir_count = '0;
        mir_row = '0;
        mir_col = '0;
        mir_loaded = 1'b0;
        mir_row_ptr[0] = '0;
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i <= MAX_ROWS; i++)
            mir_row_ptr[i] = '0;
        mir_rows = SIZE_W'(MAX_ROWS);
        mir_cols = SIZE_W'(MAX_COLS);
        mirror_restart();
    endfunction

    // Either size write restarts the load; other indexes are ignored.
    function automatic void mirror_size_write(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [SIZE_W-1:0] val);
        if (idx == csrbm_pkg::CFG_ROWS_IN_USE)
        begin
            mir_rows = fit_size(val, MAX_ROWS);
            mirror_restart();
        end
        else if (idx == csrbm_pkg::CFG_COLS_IN_USE)
        begin
            mir_cols = fit_size(val, MAX_COLS);
            mirror_restart();
        end
    endfunction

    // Scan one row's stored column indices; the row under load ends at the count.
    function automatic logic mirror_row_has(input logic [QROW_W-1:0] row,
                                            input logic [QCOL_W-1:0] col);
        int first_idx;
        int last_idx;
        if (!mir_loaded && row > mir_row)
            return 1'b0;
        first_idx = mir_row_ptr[row];
        if (!mir_loaded && row == mir_row)
            last_idx = mir_count;
        else
            last_idx = mir_row_ptr[row + 1];
        for (int i = first_idx; i < last_idx; i++)
        begin
            if (mir_col_store[i] == col)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic csr_answer_t mirror_word(input csr_word_t w);
        csr_answer_t a;
        a = '0;
        if (w.mode == csrbm_pkg::MODE_LOAD)
        begin
            // The first bit after a complete matrix begins a new one.
            if (mir_loaded)
                mirror_restart();
            if (w.bit_value && mir_count < STORE_DEPTH)
            begin
                mir_col_store[mir_count] = mir_col;
                mir_count = mir_count + 1'b1;
            end
            if (int'(mir_col) + 1 >= int'(mir_cols))
            begin
                mir_col = '0;
                mir_row = mir_row + 1'b1;
                mir_row_ptr[mir_row] = mir_count;
                if (mir_row >= mir_rows)
                    mir_loaded = 1'b1;
            end
            else
            begin
                mir_col = mir_col + 1'b1;
            end
        end
        else if (w.query_row >= mir_rows || w.query_col >= mir_cols)
        begin
            a.bad_address = 1'b1;
        end
        else
        begin
            a.hit = mirror_row_has(w.query_row, w.query_col);
        end
        a.stored_count = mir_count;
        a.load_complete = mir_loaded;
        return a;
    endfunction

    // Clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Command driver: offers queued words and predicts each one as it is taken.
    always @(posedge clk)
    begin : launch_words
        csr_word_t   nxt;
        csr_answer_t ans;
        logic        start_next;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            start_next = start;
            if (start && !busy)
            begin
                ans = mirror_word(word_on_bus);
                answers_due.insert(answers_due.size(), ans);
                if (word_on_bus.mode == csrbm_pkg::MODE_LOAD)
                begin
                    loads_taken++;
                    if (ans.load_complete)
                        matrices_done++;
                end
                else
                begin
                    queries_taken++;
                    if (ans.bad_address)
                        flagged_bad++;
                    if (ans.hit)
                        hits_seen++;
                end
                start_next = 1'b0;
            end
            if (!start_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (words_to_send.size() > 0)
                begin
                    nxt = words_to_send.pop_front();
                    word_on_bus = nxt;
                    mode <= nxt.mode;
                    bit_value <= nxt.bit_value;
                    query_row <= nxt.query_row;
                    query_col <= nxt.query_col;
                    start_next = 1'b1;
                    if (gap_odds > 0 && $urandom_range(0, 9) < gap_odds)
                        gap_left = $urandom_range(1, 8);
                end
            end
            start <= start_next;
        end
    end

    // Result checker: every strobed word must match the oldest prediction.
    always @(posedge clk)
    begin : check_answers
        csr_answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result word with no command outstanding");
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                words_in_flight--;
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    fail_count++;
                end
                if (bad_address !== want.bad_address)
                begin
                    $error("bad_address: expected %0d, got %0d", want.bad_address, bad_address);
                    fail_count++;
                end
                if (stored_count !== want.stored_count)
                begin
                    $error("stored_count: expected %0d, got %0d", want.stored_count, stored_count);
                    fail_count++;
                end
                if (load_complete !== want.load_complete)
                begin
                    $error("load_complete: expected %0d, got %0d",
                           want.load_complete, load_complete);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_word(input logic m, input logic b,
                              input logic [QROW_W-1:0] r, input logic [QCOL_W-1:0] c);
        csr_word_t w;
        w.mode = m;
        w.bit_value = b;
        w.query_row = r;
        w.query_col = c;
        words_in_flight++;
        words_queued++;
        words_to_send.insert(words_to_send.size(), w);
    endtask

    // Load words carry random query fields, which the block ignores.
    task automatic queue_load(input logic b);
        queue_word(csrbm_pkg::MODE_LOAD, b, QROW_W'($urandom_range(0, 63)),
                   QCOL_W'($urandom_range(0, 63)));
    endtask

    task automatic queue_query(input int r, input int c);
        queue_word(csrbm_pkg::MODE_QUERY, 1'($urandom_range(0, 1)), QROW_W'(r), QCOL_W'(c));
    endtask

    // Mostly in-range queries, with some anywhere in the field range.
    task automatic queue_some_query();
        if ($urandom_range(0, 4) == 0)
            queue_query($urandom_range(0, 63), $urandom_range(0, 63));
        else
            queue_query($urandom_range(0, int'(mir_rows) - 1),
                        $urandom_range(0, int'(mir_cols) - 1));
    endtask

    // Wait until every queued word has been answered.
    task automatic wait_quiet();
        do @(posedge clk); while (words_in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        wait_quiet();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        mirror_size_write(idx, val);
        size_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Load the given number of dense bits with the given share of ones, queries mixed in.
    task automatic queue_matrix(input int bits, input int ones_pct, input int query_pct);
        for (int i = 0; i < bits; i++)
        begin
            if ($urandom_range(0, 99) < query_pct)
                queue_some_query();
            queue_load($urandom_range(0, 99) < ones_pct);
        end
    endtask

    // Stimulus.
    initial
    begin : stimulus
        int directed_words;
        int pick;
        int cells;
        logic [SIZE_W-1:0] raw_rows;
        logic [SIZE_W-1:0] raw_cols;
        int phase_no;

        mirror_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default 64 x 64: queries before any row is finished.
        gap_odds = 3;
        queue_query(0, 0);
        queue_query(63, 63);
        queue_load(1'b1);
        queue_load(1'b0);
        queue_query(0, 0);
        queue_query(0, 1);
        write_size(CFG_SPARE_IDX, 7'h7F);
        queue_query(0, 0);

        // A 2 x 3 matrix: in-load and out-of-range queries, then reload.
        write_size(csrbm_pkg::CFG_ROWS_IN_USE, 7'd2);
        write_size(csrbm_pkg::CFG_COLS_IN_USE, 7'd3);
        queue_load(1'b1);
        queue_load(1'b0);
        queue_load(1'b1);
        queue_query(0, 2);
        queue_query(0, 1);
        queue_query(1, 0);
        queue_query(2, 0);
        queue_query(0, 3);
        queue_load(1'b1);
        queue_load(1'b1);
        queue_query(1, 1);
        queue_load(1'b1);
        queue_query(1, 2);
        queue_query(0, 0);
        queue_load(1'b0);
        queue_query(0, 0);
        wait_quiet();
        directed_words = words_queued;

        // Random matrices of varied shape and density.
        phase_no = 0;
        while (words_queued < directed_words + RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (phase_no == 0)
            begin
                raw_rows = 7'd0;
                raw_cols = 7'h7F;
            end
            else if (phase_no == 1)
            begin
                raw_rows = 7'd64;
                raw_cols = 7'd1;
            end
            else if (pick == 0)
            begin
                raw_rows = 7'd64;
                raw_cols = SIZE_W'($urandom_range(1, 3));
            end
            else if (pick == 1)
            begin
                raw_rows = SIZE_W'($urandom_range(1, 3));
                raw_cols = ($urandom_range(0, 1) == 0) ? 7'd64 : SIZE_W'($urandom_range(65, 127));
            end
            else if (pick == 2)
            begin
                raw_rows = SIZE_W'($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 6));
                raw_cols = SIZE_W'($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 6));
            end
            else
            begin
                raw_rows = SIZE_W'($urandom_range(1, 8));
                raw_cols = SIZE_W'($urandom_range(1, 8));
            end
            phase_no++;

            if (words_queued > directed_words + RANDOM_WORDS - 250)
                gap_odds = 0;
            else
                gap_odds = $urandom_range(0, 4);

            if ($urandom_range(0, 1) == 0)
            begin
                write_size(csrbm_pkg::CFG_ROWS_IN_USE, raw_rows);
                write_size(csrbm_pkg::CFG_COLS_IN_USE, raw_cols);
            end
            else
            begin
                write_size(csrbm_pkg::CFG_COLS_IN_USE, raw_cols);
                write_size(csrbm_pkg::CFG_ROWS_IN_USE, raw_rows);
            end
            cells = int'(mir_rows) * int'(mir_cols);

            // Now and then a load is cut short and the next write restarts it.
            if ($urandom_range(0, 5) == 0)
            begin
                queue_matrix($urandom_range(1, cells), $urandom_range(0, 100), 20);
                repeat ($urandom_range(2, 8)) queue_some_query();
                continue;
            end

            queue_matrix(cells, $urandom_range(0, 100), 15);
            if ($urandom_range(0, 3) == 0)
                wait_quiet();
            repeat ($urandom_range(5, 20)) queue_some_query();

            // A second load over the finished matrix.
            if ($urandom_range(0, 2) == 0)
            begin
                queue_matrix($urandom_range(1, cells), $urandom_range(0, 100), 20);
                repeat ($urandom_range(2, 8)) queue_some_query();
            end
        end

        // Drain, then watch for stray result words.
        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d words: %0d loads, %0d queries (%0d hits, %0d out of range).",
                 words_queued, loads_taken, queries_taken, hits_seen, flagged_bad);
        $display("Completed %0d matrices over %0d size-register writes.",
                 matrices_done, size_writes);
        if (fail_count == 0)
            $display("[csr_bool_matrix_store_unit] OK");
        else
            $display("[csr_bool_matrix_store_unit] ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("[csr_bool_matrix_store_unit] ERROR");
        $finish;
    end

endmodule
